/* design/ddft_pkg.sv */
// Shared widths, codes and defaults for the depth-difference feature test unit.
package ddft_pkg;

  // Field widths
  localparam int unsigned DEPTH_W  = 16;
  localparam int unsigned IMG_W    = 2;
  localparam int unsigned PIX_W    = 7;
  localparam int unsigned THR_W    = 17;
  localparam int unsigned OFF_W    = 19;
  localparam int unsigned DELTA_W  = 17;

  // Divider: numerator is 2*offset, magnitude up to 2^19
  localparam int unsigned NUM_W    = OFF_W + 1;
  // Quotient with sign
  localparam int unsigned QUO_W    = NUM_W + 1;
  // Centre coordinate plus quotient
  localparam int unsigned COORD_W  = QUO_W + 1;

  // Default geometry
  localparam int unsigned DEF_IMAGE_ROWS = 128;
  localparam int unsigned DEF_IMAGE_COLS = 128;
  localparam int unsigned DEF_NUM_IMAGES = 4;

  // Action codes
  localparam logic ACT_WRITE = 1'b0;
  localparam logic ACT_TEST  = 1'b1;

  // Divider lanes
  localparam int unsigned LANES  = 4;
  localparam int unsigned LANE_UR = 0;
  localparam int unsigned LANE_UC = 1;
  localparam int unsigned LANE_VR = 2;
  localparam int unsigned LANE_VC = 3;

endpackage

/* design/ddft_ram.sv */
// Generic single-port synchronous RAM with registered read data.
module ddft_ram #(
  parameter int unsigned WIDTH = 16,
  parameter int unsigned DEPTH = 1024
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] addr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[addr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[addr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

/* design/depth_difference_feature_test_unit.sv */
// Top level of the depth-difference feature test unit.
// Usage:
//   One input channel (in_valid_i / in_ready_o) carries two kinds of
//   transaction. action_i = write stores depth_value_i at (image_id_i,
//   pixel_row_i, pixel_col_i); it produces no result. action_i = test reads
//   the centre depth d, forms two probes centre + trunc(2*offset/d), clamps
//   them to the image, and returns one result transaction on the output
//   channel (out_valid_o / out_ready_i).
// Sequence and throughput:
//   A test runs from acceptance to out_valid_o through one centre read, the
//   radix-2 divider (four lanes, one per offset component, one quotient bit
//   per cycle), two probe reads on the single RAM port, a compare state and
//   the output load. A zero or out-of-range centre skips the divider and goes
//   straight to the output load. A new test is taken only once the last one
//   is in the output register; writes are taken one per cycle while idle.
// Reset and stalls:
//   rst_ni clears the sequencer and the output valid; the depth store holds
//   garbage until written. A finished result waits in the output register
//   while the next transaction is worked on; the unit holds in its result
//   state only if the next result is ready before the previous one is taken.
module depth_difference_feature_test_unit #(
  parameter int unsigned IMAGE_ROWS = ddft_pkg::DEF_IMAGE_ROWS,
  parameter int unsigned IMAGE_COLS = ddft_pkg::DEF_IMAGE_COLS,
  parameter int unsigned NUM_IMAGES = ddft_pkg::DEF_NUM_IMAGES
) (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  logic                               in_valid_i,
  output logic                               in_ready_o,
  input  logic                               action_i,
  input  logic [ddft_pkg::IMG_W-1:0]         image_id_i,
  input  logic [ddft_pkg::PIX_W-1:0]         pixel_row_i,
  input  logic [ddft_pkg::PIX_W-1:0]         pixel_col_i,
  input  logic [ddft_pkg::DEPTH_W-1:0]       depth_value_i,
  input  logic signed [ddft_pkg::THR_W-1:0]  threshold_i,
  input  logic signed [ddft_pkg::OFF_W-1:0]  offset_u_row_i,
  input  logic signed [ddft_pkg::OFF_W-1:0]  offset_u_col_i,
  input  logic signed [ddft_pkg::OFF_W-1:0]  offset_v_row_i,
  input  logic signed [ddft_pkg::OFF_W-1:0]  offset_v_col_i,
  output logic                               out_valid_o,
  input  logic                               out_ready_i,
  output logic                               goes_right_o,
  output logic signed [ddft_pkg::DELTA_W-1:0] depth_delta_o,
  output logic                               center_invalid_o
);

  import ddft_pkg::*;

  localparam int unsigned StoreDepth = NUM_IMAGES * IMAGE_ROWS * IMAGE_COLS;
  localparam int unsigned AddrW      = $clog2(StoreDepth);
  localparam int unsigned RowW       = $clog2(IMAGE_ROWS);
  localparam int unsigned ColW       = $clog2(IMAGE_COLS);
  localparam int unsigned CntW       = $clog2(NUM_W);

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_CENTER,
    ST_DIV,
    ST_RD_U,
    ST_RD_V,
    ST_CMP,
    ST_RESULT
  } state_e;

  state_e state_q;

  // Captured test transaction
  logic [IMG_W-1:0]         img_q;
  logic [PIX_W-1:0]         row_q;
  logic [PIX_W-1:0]         col_q;
  logic signed [THR_W-1:0]  thr_q;
  logic signed [OFF_W-1:0]  off_q [LANES];
  logic                     ctr_ok_q;

  // Divider lanes: num_q shifts the dividend out and the quotient in
  logic [DEPTH_W-1:0]       div_d_q;
  logic [NUM_W-1:0]         num_q  [LANES];
  logic [DEPTH_W-1:0]       rem_q  [LANES];
  logic                     neg_q  [LANES];
  logic [CntW-1:0]          cnt_q;

  logic [DEPTH_W-1:0]       pu_q;
  logic                     res_go_q;
  logic signed [DELTA_W-1:0] res_delta_q;
  logic                     res_inv_q;

  // RAM port
  logic                     ram_we;
  logic                     ram_re;
  logic [AddrW-1:0]         ram_addr;
  logic [DEPTH_W-1:0]       ram_rdata;

  logic                     in_fire;
  logic                     in_addr_ok;
  logic [AddrW-1:0]         in_addr;
  logic [AddrW-1:0]         addr_u;
  logic [AddrW-1:0]         addr_v;
  logic [COORD_W-1:0]       coord [LANES];

  logic [DEPTH_W:0]         trial [LANES];
  logic                     qbit  [LANES];
  logic signed [DELTA_W-1:0] delta;
  logic                     out_free;

  function automatic logic [AddrW-1:0] addr_of(input logic [IMG_W-1:0] img,
                                               input logic [COORD_W-1:0] row,
                                               input logic [COORD_W-1:0] col);
    addr_of = AddrW'(img) * AddrW'(IMAGE_ROWS * IMAGE_COLS)
            + AddrW'(row) * AddrW'(IMAGE_COLS) + AddrW'(col);
  endfunction

  // Saturate a signed coordinate to 0 .. size-1
  function automatic logic [COORD_W-1:0] clamp_coord(input logic signed [COORD_W-1:0] v,
                                                     input int unsigned size);
    logic signed [COORD_W-1:0] lim;
    lim = COORD_W'(size);
    if (v < 0) begin
      clamp_coord = '0;
    end else if (v >= lim) begin
      clamp_coord = COORD_W'(size - 1);
    end else begin
      clamp_coord = v;
    end
  endfunction

  assign in_ready_o = (state_q == ST_IDLE);
  assign in_fire    = in_valid_i && in_ready_o;
  assign in_addr_ok = (32'(image_id_i) < 32'(NUM_IMAGES)) &&
                      (32'(pixel_row_i) < 32'(IMAGE_ROWS)) &&
                      (32'(pixel_col_i) < 32'(IMAGE_COLS));
  assign in_addr    = addr_of(image_id_i, COORD_W'(pixel_row_i), COORD_W'(pixel_col_i));
  assign out_free   = !out_valid_o || out_ready_i;

  // Probe coordinates from the signed quotients
  always_comb begin
    logic signed [QUO_W-1:0]   quo;
    logic signed [COORD_W-1:0] sum;
    logic [PIX_W-1:0]          base;
    for (int k = 0; k < LANES; k++) begin
      quo  = neg_q[k] ? -$signed({1'b0, num_q[k]}) : $signed({1'b0, num_q[k]});
      base = (k == LANE_UR || k == LANE_VR) ? row_q : col_q;
      sum  = $signed(COORD_W'(base)) + COORD_W'(quo);
      coord[k] = (k == LANE_UR || k == LANE_VR) ? clamp_coord(sum, IMAGE_ROWS)
                                               : clamp_coord(sum, IMAGE_COLS);
    end
  end

  assign addr_u = addr_of(img_q, COORD_W'(coord[LANE_UR][RowW-1:0]),
                          COORD_W'(coord[LANE_UC][ColW-1:0]));
  assign addr_v = addr_of(img_q, COORD_W'(coord[LANE_VR][RowW-1:0]),
                          COORD_W'(coord[LANE_VC][ColW-1:0]));

  // RAM access per state
  always_comb begin
    ram_we   = 1'b0;
    ram_re   = 1'b0;
    ram_addr = in_addr;
    unique case (state_q)
      ST_IDLE: begin
        ram_we = in_fire && (action_i == ACT_WRITE) && in_addr_ok;
        ram_re = in_fire && (action_i == ACT_TEST);
      end
      ST_RD_U: begin
        ram_re   = 1'b1;
        ram_addr = addr_u;
      end
      ST_RD_V: begin
        ram_re   = 1'b1;
        ram_addr = addr_v;
      end
      default: begin
        ram_re = 1'b0;
      end
    endcase
  end

  ddft_ram #(
    .WIDTH (DEPTH_W),
    .DEPTH (StoreDepth)
  ) u_store (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .re_i    (ram_re),
    .addr_i  (ram_addr),
    .wdata_i (depth_value_i),
    .rdata_o (ram_rdata)
  );

  // One restoring divide step per lane
  always_comb begin
    for (int k = 0; k < LANES; k++) begin
      trial[k] = {rem_q[k], num_q[k][NUM_W-1]};
      qbit[k]  = (trial[k] >= {1'b0, div_d_q});
    end
  end

  assign delta = $signed({1'b0, pu_q}) - $signed({1'b0, ram_rdata});

  // Datapath registers
  always_ff @(posedge clk_i) begin
    logic signed [NUM_W-1:0] twice;
    if (in_fire && (action_i == ACT_TEST)) begin
      img_q    <= image_id_i;
      row_q    <= pixel_row_i;
      col_q    <= pixel_col_i;
      thr_q    <= threshold_i;
      ctr_ok_q <= in_addr_ok;
      off_q[LANE_UR] <= offset_u_row_i;
      off_q[LANE_UC] <= offset_u_col_i;
      off_q[LANE_VR] <= offset_v_row_i;
      off_q[LANE_VC] <= offset_v_col_i;
    end
    unique case (state_q)
      ST_CENTER: begin
        div_d_q <= ram_rdata;
        for (int k = 0; k < LANES; k++) begin
          twice    = {off_q[k], 1'b0};
          neg_q[k] <= twice[NUM_W-1];
          num_q[k] <= twice[NUM_W-1] ? NUM_W'(-twice) : NUM_W'(twice);
          rem_q[k] <= '0;
        end
      end
      ST_DIV: begin
        for (int k = 0; k < LANES; k++) begin
          rem_q[k] <= qbit[k] ? DEPTH_W'(trial[k] - {1'b0, div_d_q}) : trial[k][DEPTH_W-1:0];
          num_q[k] <= {num_q[k][NUM_W-2:0], qbit[k]};
        end
      end
      ST_RD_V: begin
        pu_q <= ram_rdata;
      end
      default: begin
      end
    endcase
  end

  // Sequencer and output register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q          <= ST_IDLE;
      cnt_q            <= '0;
      res_go_q         <= 1'b0;
      res_delta_q      <= '0;
      res_inv_q        <= 1'b0;
      out_valid_o      <= 1'b0;
      goes_right_o     <= 1'b0;
      depth_delta_o    <= '0;
      center_invalid_o <= 1'b0;
    end else begin
      // load a finished result, else drop valid once taken
      if ((state_q == ST_RESULT) && out_free) begin
        out_valid_o <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_o <= 1'b0;
      end
      unique case (state_q)
        ST_IDLE: begin
          if (in_fire && (action_i == ACT_TEST)) begin
            state_q <= ST_CENTER;
          end
        end
        ST_CENTER: begin
          if (!ctr_ok_q || (ram_rdata == '0)) begin
            res_go_q    <= 1'b0;
            res_delta_q <= '0;
            res_inv_q   <= 1'b1;
            state_q     <= ST_RESULT;
          end else begin
            cnt_q   <= '0;
            state_q <= ST_DIV;
          end
        end
        ST_DIV: begin
          cnt_q <= cnt_q + 1'b1;
          if (cnt_q == CntW'(NUM_W - 1)) begin
            state_q <= ST_RD_U;
          end
        end
        ST_RD_U: begin
          state_q <= ST_RD_V;
        end
        ST_RD_V: begin
          state_q <= ST_CMP;
        end
        ST_CMP: begin
          res_go_q    <= (delta > thr_q);
          res_delta_q <= delta;
          res_inv_q   <= 1'b0;
          state_q     <= ST_RESULT;
        end
        ST_RESULT: begin
          if (out_free) begin
            goes_right_o     <= res_go_q;
            depth_delta_o    <= res_delta_q;
            center_invalid_o <= res_inv_q;
            state_q          <= ST_IDLE;
          end
        end
        default: begin
          state_q <= ST_IDLE;
        end
      endcase
    end
  end

endmodule
